@@ rtl/plen_pkg.sv @@
// Shared constants, codes and controller/datapath command and status types for the list engine.
package plen_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int PTR_W = IDX_W + 1;
    localparam int CNT_W = 9;
    localparam int VAL_W = 32;
    localparam int OP_W = 3;
    localparam int POS_W = 10;
    localparam int ST_W = 2;

    localparam logic [PTR_W-1:0] LINK_NULL = PTR_W'(CAPACITY);

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_END = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_END = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS = 3'd5;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic accept;
        logic finish_err;
        logic alloc_free;
        logic alloc_take;
        logic alloc_fresh;
        logic write_val;
        logic link_head_ins;
        logic walk_start;
        logic walk_step;
        logic ins_link_slot;
        logic ins_link_prev;
        logic del_head_start;
        logic del_head_done;
        logic del_walk_done;
        logic del_link_done;
        logic free_slot;
        logic finish_ok;
    } plen_cmd_t;

    typedef struct packed {
        logic err;
        logic is_ins_in;
        logic is_ins;
        logic k_zero;
        logic free_avail;
        logic rem_zero;
        logic out_valid;
    } plen_sts_t;

endpackage

@@ rtl/plen_req_if.sv @@
// Request channel carrying one list operation.
interface plen_req_if import plen_pkg::*;;
    logic valid;
    logic ready;
    logic [OP_W-1:0] opcode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0] position;

    modport source (output valid, opcode, value, position, input ready);
    modport sink (input valid, opcode, value, position, output ready);
endinterface

@@ rtl/plen_rsp_if.sv @@
// Response channel carrying the result of one list operation.
interface plen_rsp_if import plen_pkg::*;;
    logic valid;
    logic ready;
    logic [ST_W-1:0] status;
    logic removed_valid;
    logic signed [VAL_W-1:0] removed_value;
    logic [CNT_W-1:0] length;

    modport source (output valid, status, removed_valid, removed_value, length, input ready);
    modport sink (input valid, status, removed_valid, removed_value, length, output ready);
endinterface

@@ rtl/plen_ctrl.sv @@
// Sequencing state machine of the list engine.
module plen_ctrl import plen_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  logic      rsp_ready,
    input  plen_sts_t sts,
    output plen_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_ALLOC    = 10'b0000000010,
        S_ALLOC_W  = 10'b0000000100,
        S_PLACE    = 10'b0000001000,
        S_WALK     = 10'b0000010000,
        S_INS_PREV = 10'b0000100000,
        S_DSTART   = 10'b0001000000,
        S_DEL_HEAD = 10'b0010000000,
        S_DEL_LINK = 10'b0100000000,
        S_FREE     = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE) && (!sts.out_valid || rsp_ready);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd.accept = 1'b1;
                    if (sts.err)
                    begin
                        cmd.finish_err = 1'b1;
                    end
                    else if (sts.is_ins_in)
                    begin
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        state_next = S_DSTART;
                    end
                end
            end
            S_ALLOC:
            begin
                if (sts.free_avail)
                begin
                    cmd.alloc_free = 1'b1;
                    state_next = S_ALLOC_W;
                end
                else
                begin
                    cmd.alloc_fresh = 1'b1;
                    state_next = S_PLACE;
                end
            end
            S_ALLOC_W:
            begin
                cmd.alloc_take = 1'b1;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.write_val = 1'b1;
                if (sts.k_zero)
                begin
                    cmd.link_head_ins = 1'b1;
                    cmd.finish_ok = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (!sts.rem_zero)
                begin
                    cmd.walk_step = 1'b1;
                end
                else if (sts.is_ins)
                begin
                    cmd.ins_link_slot = 1'b1;
                    state_next = S_INS_PREV;
                end
                else
                begin
                    cmd.del_walk_done = 1'b1;
                    state_next = S_DEL_LINK;
                end
            end
            S_INS_PREV:
            begin
                cmd.ins_link_prev = 1'b1;
                cmd.finish_ok = 1'b1;
                state_next = S_IDLE;
            end
            S_DSTART:
            begin
                if (sts.k_zero)
                begin
                    cmd.del_head_start = 1'b1;
                    state_next = S_DEL_HEAD;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_DEL_HEAD:
            begin
                cmd.del_head_done = 1'b1;
                state_next = S_FREE;
            end
            S_DEL_LINK:
            begin
                cmd.del_link_done = 1'b1;
                state_next = S_FREE;
            end
            S_FREE:
            begin
                cmd.free_slot = 1'b1;
                cmd.finish_ok = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/plen_dp.sv @@
// Node store, list pointers, chain walker and result register of the list engine.
module plen_dp import plen_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  plen_cmd_t               cmd,
    output plen_sts_t               sts,
    input  logic [OP_W-1:0]         req_opcode,
    input  logic signed [VAL_W-1:0] req_value,
    input  logic [POS_W-1:0]        req_position,
    input  logic                    rsp_ready,
    output logic                    rsp_valid,
    output logic [ST_W-1:0]         rsp_status,
    output logic                    rsp_removed_valid,
    output logic signed [VAL_W-1:0] rsp_removed_value,
    output logic [CNT_W-1:0]        rsp_length
);

    logic [PTR_W-1:0] link_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem [CAPACITY];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] free_head_reg, free_head_next;
    logic [PTR_W-1:0] fresh_reg, fresh_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    logic             ins_reg;
    logic [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0] k_reg;
    logic [PTR_W-1:0] cur_reg;
    logic [PTR_W-1:0] slot_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [VAL_W-1:0] removed_reg;
    logic [PTR_W-1:0] link_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;

    logic [ST_W-1:0]  status_reg;
    logic             rv_reg;
    logic [VAL_W-1:0] rval_reg;
    logic [CNT_W-1:0] length_reg;

    logic             err_in;
    logic [ST_W-1:0]  code_in;
    logic [CNT_W-1:0] k_in;
    logic             ins_in;
    logic             full;
    logic [POS_W-1:0] cnt_w;

    logic [IDX_W-1:0] rd_addr;
    logic             link_we;
    logic [IDX_W-1:0] link_wa;
    logic [PTR_W-1:0] link_wd;

    assign full = (count_reg == CNT_W'(CAPACITY));
    assign cnt_w = POS_W'(count_reg);

    always_comb
    begin
        err_in = 1'b0;
        code_in = ST_OK;
        k_in = '0;
        ins_in = 1'b0;
        case (req_opcode)
            OP_INS_FRONT:
            begin
                ins_in = 1'b1;
                err_in = full;
                code_in = ST_FULL;
            end
            OP_INS_END:
            begin
                ins_in = 1'b1;
                err_in = full;
                code_in = ST_FULL;
                k_in = count_reg;
            end
            OP_INS_POS:
            begin
                ins_in = 1'b1;
                k_in = CNT_W'(req_position - POS_W'(1));
                if (full)
                begin
                    err_in = 1'b1;
                    code_in = ST_FULL;
                end
                else if (req_position == '0 || req_position > cnt_w + POS_W'(1))
                begin
                    err_in = 1'b1;
                    code_in = ST_BADPOS;
                end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS:
            begin
                if (req_opcode == OP_DEL_END)
                begin
                    k_in = count_reg - CNT_W'(1);
                end
                else if (req_opcode == OP_DEL_POS)
                begin
                    k_in = CNT_W'(req_position - POS_W'(1));
                end
                if (count_reg == '0)
                begin
                    err_in = 1'b1;
                    code_in = ST_EMPTY;
                end
                else if (req_opcode == OP_DEL_POS
                         && (req_position == '0 || req_position > cnt_w))
                begin
                    err_in = 1'b1;
                    code_in = ST_BADPOS;
                end
            end
            default:
            begin
                err_in = 1'b1;
                code_in = ST_OK;
            end
        endcase
    end

    assign sts.err = err_in;
    assign sts.is_ins_in = ins_in;
    assign sts.is_ins = ins_reg;
    assign sts.k_zero = (k_reg == '0);
    assign sts.free_avail = (free_head_reg != LINK_NULL);
    assign sts.rem_zero = (rem_reg == '0);
    assign sts.out_valid = out_valid_reg;

    always_comb
    begin
        rd_addr = link_rd_reg[IDX_W-1:0];
        if (cmd.alloc_free)
        begin
            rd_addr = free_head_reg[IDX_W-1:0];
        end
        else if (cmd.walk_start || cmd.del_head_start)
        begin
            rd_addr = head_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        link_we = 1'b1;
        link_wa = slot_reg[IDX_W-1:0];
        link_wd = free_head_reg;
        if (cmd.link_head_ins)
        begin
            link_wd = head_reg;
        end
        else if (cmd.ins_link_slot)
        begin
            link_wd = link_rd_reg;
        end
        else if (cmd.ins_link_prev)
        begin
            link_wa = cur_reg[IDX_W-1:0];
            link_wd = slot_reg;
        end
        else if (cmd.del_link_done)
        begin
            link_wa = cur_reg[IDX_W-1:0];
            link_wd = link_rd_reg;
        end
        else if (!cmd.free_slot)
        begin
            link_we = 1'b0;
        end
    end

    always_comb
    begin
        head_next = head_reg;
        free_head_next = free_head_reg;
        fresh_next = fresh_reg;
        count_next = count_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        if (cmd.alloc_take)
        begin
            free_head_next = link_rd_reg;
        end
        if (cmd.alloc_fresh)
        begin
            fresh_next = fresh_reg + PTR_W'(1);
        end
        if (cmd.link_head_ins)
        begin
            head_next = slot_reg;
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.ins_link_prev)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.del_head_done)
        begin
            head_next = link_rd_reg;
        end
        if (cmd.free_slot)
        begin
            free_head_next = slot_reg;
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.finish_ok || cmd.finish_err)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= LINK_NULL;
            free_head_reg <= LINK_NULL;
            fresh_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            free_head_reg <= free_head_next;
            fresh_reg <= fresh_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        link_rd_reg <= link_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.write_val)
        begin
            val_mem[slot_reg[IDX_W-1:0]] <= val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ins_reg <= ins_in;
            val_reg <= req_value;
            k_reg <= k_in;
        end
        if (cmd.alloc_free)
        begin
            slot_reg <= free_head_reg;
        end
        if (cmd.alloc_fresh)
        begin
            slot_reg <= fresh_reg;
        end
        if (cmd.del_head_start)
        begin
            slot_reg <= head_reg;
        end
        if (cmd.del_walk_done)
        begin
            slot_reg <= link_rd_reg;
        end
        if (cmd.walk_start)
        begin
            cur_reg <= head_reg;
            rem_reg <= k_reg - CNT_W'(1);
        end
        if (cmd.walk_step)
        begin
            cur_reg <= link_rd_reg;
            rem_reg <= rem_reg - CNT_W'(1);
        end
        if (cmd.del_head_done || cmd.del_link_done)
        begin
            removed_reg <= val_rd_reg;
        end
        if (cmd.finish_err)
        begin
            status_reg <= code_in;
            rv_reg <= 1'b0;
            rval_reg <= '0;
            length_reg <= count_reg;
        end
        if (cmd.finish_ok)
        begin
            status_reg <= ST_OK;
            rv_reg <= cmd.free_slot;
            rval_reg <= cmd.free_slot ? removed_reg : '0;
            length_reg <= count_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_status = status_reg;
    assign rsp_removed_valid = rv_reg;
    assign rsp_removed_value = rval_reg;
    assign rsp_length = length_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= PTR_W'(CAPACITY))
        else $error("fresh slot counter above capacity");

    a_free_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_slot |=> free_head_reg != LINK_NULL)
        else $error("freed slot not on free chain");

    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rv_reg |-> status_reg == ST_OK)
        else $error("removed value reported with failure status");

    a_head_ins: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link_head_ins |=> head_reg != LINK_NULL && count_reg != '0)
        else $error("front insert left list empty");

endmodule

@@ rtl/positional_list_engine_core.sv @@
// Top level of the positional list engine: controller plus datapath.
//
// A bounded ordered list of up to 256 signed 32-bit values, kept as linked
// nodes in a block memory with a free chain. The req channel carries one
// operation per transfer (insert or delete at the front, the end or a
// 1-based position); the rsp channel returns one transfer per request with
// status, removed value and new length.
// Rejected requests and unused opcodes answer in the cycle after the request
// transfer. End and positional operations walk the link chain one node per
// cycle through the single memory read port. One request is in progress at
// a time; the next request is taken at the earliest in the cycle in which the
// previous result transfers on rsp.
// Reset empties the list at once; no clearing pass is needed, since unused
// slots are handed out by a counter. When the receiver stalls, the result
// holds on rsp and no new request is taken until it transfers.
module positional_list_engine_core import plen_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    plen_req_if.sink   req,
    plen_rsp_if.source rsp
);

    plen_cmd_t cmd;
    plen_sts_t sts;

    plen_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    plen_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req_opcode        (req.opcode),
        .req_value         (req.value),
        .req_position      (req.position),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .rsp_status        (rsp.status),
        .rsp_removed_valid (rsp.removed_valid),
        .rsp_removed_value (rsp.removed_value),
        .rsp_length        (rsp.length)
    );

endmodule
